// ===== hw/rtl/rap_pkg.sv =====
// Shared types and constants for the 2x2 RGB average pooling unit.
package rap_pkg;

  localparam int unsigned MaxWidthDefault = 1024;
  localparam int unsigned ChanW           = 8;
  localparam int unsigned PairW           = ChanW + 1;
  localparam int unsigned WidthW          = 11;
  localparam int unsigned HeightW         = 13;
  localparam int unsigned RowW            = 12;
  localparam int unsigned CfgIdxW         = 2;
  localparam int unsigned CfgDataW        = 13;
  localparam int unsigned MaxHeight       = 4096;
  localparam int unsigned ResetWidth      = 640;
  localparam int unsigned ResetHeight     = 480;
  localparam int unsigned QueueDepth      = 4;
  // divide by the four samples of a window: drop two bits
  localparam int unsigned PoolShift       = 2;

  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 2'd1;

  typedef enum logic [1:0] {
    KIND_LEFT,  // left pixel of a pair: load partial register
    KIND_PAIR,  // upper window row: store pair sum in line buffer
    KIND_EMIT   // lower window row: finish window and emit
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic             row_end;
    logic             frame_end;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } rap_req_t;

  localparam int unsigned ReqW = $bits(rap_req_t);

endpackage

// ===== hw/rtl/rap_front.sv =====
// Front end: config registers, raster counters and classification of pixels.
module rap_front #(
  parameter int unsigned MAX_WIDTH = rap_pkg::MaxWidthDefault,
  parameter int unsigned SLOT_W    = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [rap_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rap_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          pix_valid_i,
  output logic                          pix_ready_o,
  input  logic [3*rap_pkg::ChanW-1:0]   pix_data_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output rap_pkg::rap_req_t             q_req_o,
  output logic [SLOT_W-1:0]             q_slot_o
);
  import rap_pkg::*;

  localparam int unsigned ColW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CmpW = HeightW;
  localparam logic [CmpW-1:0] MaxW = CmpW'(MAX_WIDTH);
  localparam logic [CmpW-1:0] MaxH = CmpW'(MaxHeight);
  localparam logic [CmpW-1:0] Two  = CmpW'(2);
  localparam logic [CmpW-1:0] One  = CmpW'(1);

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;

  logic [CmpW-1:0] w_raw, eff_w, eff_h, last_col, last_row, col_nx, row_nx;
  logic            accept, cfg_wr;

  assign cfg_wr      = cfg_valid_i;
  assign pix_ready_o = !q_full_i;
  assign accept      = pix_valid_i && !q_full_i;

  assign w_raw    = CmpW'(width_q);
  assign eff_w    = (w_raw < Two) ? Two : ((w_raw > MaxW) ? MaxW : w_raw);
  assign eff_h    = (height_q < Two) ? Two : ((height_q > MaxH) ? MaxH : height_q);
  assign last_col = {eff_w[CmpW-1:1], 1'b0} - One;
  assign last_row = {eff_h[CmpW-1:1], 1'b0} - One;
  assign col_nx   = CmpW'(col_q) + One;
  assign row_nx   = CmpW'(row_q) + One;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_nx >= eff_w) begin
        col_d = '0;
        row_d = (row_nx >= eff_h) ? '0 : RowW'(row_nx);
      end else begin
        col_d = ColW'(col_nx);
      end
    end
  end

  always_comb begin
    q_push_o          = 1'b0;
    q_req_o.kind      = KIND_LEFT;
    q_req_o.row_end   = (CmpW'(col_q) == last_col);
    q_req_o.frame_end = (CmpW'(col_q) == last_col) && (CmpW'(row_q) == last_row);
    q_req_o.red       = pix_data_i[ChanW-1:0];
    q_req_o.green     = pix_data_i[2*ChanW-1:ChanW];
    q_req_o.blue      = pix_data_i[3*ChanW-1:2*ChanW];
    q_slot_o          = SLOT_W'(col_q >> 1);
    if (accept) begin
      if (!col_q[0]) begin
        q_push_o = 1'b1;
      end else if (CmpW'(col_q) <= last_col) begin
        if (!row_q[0]) begin
          q_req_o.kind = KIND_PAIR;
          q_push_o     = 1'b1;
        end else if (CmpW'(row_q) <= last_row) begin
          q_req_o.kind = KIND_EMIT;
          q_push_o     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthW'(ResetWidth);
      height_q <= HeightW'(ResetHeight);
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_wr && (cfg_index_i == CfgImageWidth)) begin
      width_q <= cfg_data_i[WidthW-1:0];
      col_q   <= '0;
      row_q   <= '0;
    end else if (cfg_wr && (cfg_index_i == CfgImageHeight)) begin
      height_q <= cfg_data_i;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== hw/rtl/rap_queue.sv =====
// Short request queue between front and back end.
module rap_queue #(
  parameter int unsigned DATA_W = rap_pkg::ReqW,
  parameter int unsigned DEPTH  = rap_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] pop_data_o
);
  import rap_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(DEPTH);
  localparam logic [PtrW-1:0] Last = PtrW'(DEPTH - 1);

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o     = (cnt_q == Full);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == Last) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == Last) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("request pushed into full queue");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("request popped from empty queue");
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full) else $error("queue count beyond depth");
  a_ptr_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q)) else $error("empty queue with pointer gap");
`endif

endmodule

// ===== hw/rtl/rap_back.sv =====
// Back end: pair sums, line buffer, window sum and output register.
module rap_back #(
  parameter int unsigned MAX_WIDTH = rap_pkg::MaxWidthDefault,
  parameter int unsigned SLOT_W    = 9
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_pop_o,
  input  rap_pkg::rap_req_t           q_req_i,
  input  logic [SLOT_W-1:0]           q_slot_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [3*rap_pkg::ChanW-1:0] out_data_o,  // red, green, blue
  output logic                        out_row_end_o,
  output logic                        out_frame_end_o
);
  import rap_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH / 2;
  localparam int unsigned WordW = 3 * PairW;
  localparam int unsigned SumW  = PairW + 1;

  logic [WordW-1:0]   line_mem [Depth];
  logic [WordW-1:0]   rd_q;
  logic [3*ChanW-1:0] partial_q;
  logic [WordW-1:0]   pair_d, pair_q;
  logic               s1_valid_q, s1_row_end_q, s1_frame_end_q;
  logic               out_valid_q, out_row_end_q, out_frame_end_q;
  logic [3*ChanW-1:0] out_data_q, mean_d;
  logic               s1_go, pop;

  assign s1_go   = !out_valid_q || out_ready_i;
  assign pop     = q_valid_i && (!s1_valid_q || s1_go);
  assign q_pop_o = pop;

  always_comb begin
    pair_d[PairW-1:0]         = PairW'(partial_q[ChanW-1:0]) + PairW'(q_req_i.red);
    pair_d[2*PairW-1:PairW]   = PairW'(partial_q[2*ChanW-1:ChanW]) + PairW'(q_req_i.green);
    pair_d[3*PairW-1:2*PairW] = PairW'(partial_q[3*ChanW-1:2*ChanW]) + PairW'(q_req_i.blue);
  end

  // upper pair sum + lower pair sum, then drop two bits
  always_comb begin
    logic [SumW-1:0] s;
    for (int k = 0; k < 3; k++) begin
      s = SumW'(rd_q[k*PairW +: PairW]) + SumW'(pair_q[k*PairW +: PairW]);
      mean_d[k*ChanW +: ChanW] = s[PoolShift +: ChanW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && q_req_i.kind == KIND_PAIR) begin
      line_mem[q_slot_i] <= pair_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && q_req_i.kind == KIND_EMIT) begin
      rd_q <= line_mem[q_slot_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (q_req_i.kind == KIND_LEFT) begin
        partial_q <= {q_req_i.blue, q_req_i.green, q_req_i.red};
      end
      if (q_req_i.kind == KIND_EMIT) begin
        pair_q         <= pair_d;
        s1_row_end_q   <= q_req_i.row_end;
        s1_frame_end_q <= q_req_i.frame_end;
      end
    end
    if (s1_go && s1_valid_q) begin
      out_data_q      <= mean_d;
      out_row_end_q   <= s1_row_end_q;
      out_frame_end_q <= s1_frame_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid_q <= (q_req_i.kind == KIND_EMIT);
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign out_row_end_o   = out_row_end_q;
  assign out_frame_end_o = out_frame_end_q;

`ifndef NO_ASSERTIONS
  a_s1_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |=> s1_valid_q) else $error("stalled window lost");
  a_no_pop_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |-> !pop) else $error("request popped over stalled window");
  a_frame_has_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_frame_end_q |-> out_row_end_q) else $error("frame end without row end");
`endif

endmodule

// ===== hw/rtl/rgb_average_pool_2x2_unit.sv =====
// Top level of the 2x2 RGB average pooling unit.
//
// Pixels enter on the s_axis channel in raster order, one per request, for a
// frame of image_width x image_height pixels (written on the cfg channel,
// index 0 = width, 1 = height; a write to either restarts the frame at pixel 0).
// Each non-overlapping 2x2 window yields one request on m_axis carrying the
// truncated per-channel mean; tlast marks the end of an output row and
// tuser the end of the frame. An odd last column or row is consumed silently.
// Throughput: one pixel per cycle while the queue is not full; the line buffer
// does at most one read or one write per pixel. After the bottom-right pixel of
// its window is accepted, a result passes the queue, window stage and output register.
// A four-entry queue separates the counting front end from the arithmetic
// back end; when m_axis stalls, the back end holds one window and the output
// register, the queue fills, and s_axis_tready drops once it is full.
// Reset restores 640 x 480 and empties the pipeline; line buffer contents
// are not cleared (each entry is written in the upper row before use).
module rgb_average_pool_2x2_unit #(
  parameter int unsigned MAX_WIDTH = rap_pkg::MaxWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rap_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rap_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [3*rap_pkg::ChanW-1:0]   s_axis_tdata_i,  // pixel_red, pixel_green, pixel_blue
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [3*rap_pkg::ChanW-1:0]   m_axis_tdata_o,  // out_red, out_green, out_blue
  output logic                          m_axis_tlast_o,  // row_end
  output logic                          m_axis_tuser_o   // frame_end
);
  import rap_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH / 2;
  localparam int unsigned SlotW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned EntW  = ReqW + SlotW;

  rap_req_t         f_req, b_req;
  logic [SlotW-1:0] f_slot, b_slot;
  logic             q_push, q_full, q_pop, q_valid;
  logic [EntW-1:0]  q_out;

  assign cfg_ready_o = 1'b1;

  rap_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .SLOT_W   (SlotW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .pix_valid_i(s_axis_tvalid_i),
    .pix_ready_o(s_axis_tready_o),
    .pix_data_i (s_axis_tdata_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_req_o    (f_req),
    .q_slot_o   (f_slot)
  );

  rap_queue #(
    .DATA_W(EntW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i({f_slot, f_req}),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_out)
  );

  assign b_req  = rap_req_t'(q_out[ReqW-1:0]);
  assign b_slot = q_out[EntW-1:ReqW];

  rap_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .SLOT_W   (SlotW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_req_i        (b_req),
    .q_slot_i       (b_slot),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_data_o     (m_axis_tdata_o),
    .out_row_end_o  (m_axis_tlast_o),
    .out_frame_end_o(m_axis_tuser_o)
  );

endmodule
